>>> rtl/stt_pkg.sv
// Shared types and constants for the software timer table.
// Holds slot sizing, opcode, kind, status and state codes, and the control structs.
// No dependencies.
package stt_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_SET_ACK    = 2'd0,
        KIND_REMOVE_ACK = 2'd1,
        KIND_EXPIRED    = 2'd2,
        KIND_TICK_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_TICK,
        S_TICK_END
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic scan_start;
        logic scan_step;
        logic apply;
        logic tick_start;
        logic tick_step;
        logic tick_end;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic scan_last;
        logic tick_last;
        logic table_empty;
    } t_stat;

endpackage

>>> rtl/software_timer_table.sv
// Top level of the software timer table.
// Joins the controller (stt_ctrl) and the datapath (stt_datapath); uses stt_pkg.
//
// The block keeps up to TIMER_SLOTS timers keyed by (task, signal). A command
// is transferred on a rising edge with start high and busy low; busy then stays
// high until the command is done. Set and remove scan the whole table, one slot
// per cycle, then update it in S_APPLY; the scan length is set by TIMER_SLOTS,
// not by the live timers. A tick walks the live timers newest first, one per
// cycle, then ends in S_TICK_END, which an empty table goes to at once. Opcode
// three is taken and dropped at once. Every result sits on the output ports
// for exactly one cycle, marked by o_valid, and cannot be held off: the
// receiver must take it then. Set and remove give one result; a tick gives one
// result per expired timer (at most MAX_RESULTS), or one tick-done result when
// nothing expired, and o_last marks the final result of each command.
// o_tick_count carries the running tick total in every result. Results are
// driven from a register.
module software_timer_table
    import stt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_task_id,
    input  logic [7:0]  i_signal_id,
    input  logic [30:0] i_duration,
    input  logic        i_periodic,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_status,
    output logic [7:0]  o_fired_task,
    output logic [7:0]  o_fired_signal,
    output logic        o_last,
    output logic [31:0] o_tick_count
);

    t_cmd  cmd;
    t_stat stat;

    // Sequence scan, update and tick walk
    stt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Hold the table, walk it, and drive the result register
    stt_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (i_opcode),
        .i_task_id      (i_task_id),
        .i_signal_id    (i_signal_id),
        .i_duration     (i_duration),
        .i_periodic     (i_periodic),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_status       (o_status),
        .o_fired_task   (o_fired_task),
        .o_fired_signal (o_fired_signal),
        .o_last         (o_last),
        .o_tick_count   (o_tick_count)
    );

endmodule

>>> rtl/stt_ctrl.sv
// Controller state machine of the software timer table.
// Sequences the key scan, the table update and the tick walk.
// Depends on stt_pkg.
module stt_ctrl
    import stt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_opcode,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (t_opcode'(i_opcode))
                        OP_SET, OP_REMOVE: begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                        OP_TICK: begin
                            o_cmd.tick_start = 1'b1;
                            n_state          = i_stat.table_empty ? S_TICK_END : S_TICK;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_IDLE;
            end
            S_TICK: begin
                o_cmd.tick_step = 1'b1;
                if (i_stat.tick_last) begin
                    n_state = S_TICK_END;
                end
            end
            S_TICK_END: begin
                o_cmd.tick_end = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> rtl/stt_datapath.sv
// Datapath of the software timer table: slot storage, age order list,
// key scan, tick walk and the result register. Depends on stt_pkg.
module stt_datapath
    import stt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_task_id,
    input  logic [7:0]  i_signal_id,
    input  logic [30:0] i_duration,
    input  logic        i_periodic,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_status,
    output logic [7:0]  o_fired_task,
    output logic [7:0]  o_fired_signal,
    output logic        o_last,
    output logic [31:0] o_tick_count
);

    // Slot storage
    logic [TIMER_SLOTS-1:0] r_valid;
    logic [7:0]             r_task   [TIMER_SLOTS];
    logic [7:0]             r_sig    [TIMER_SLOTS];
    logic [31:0]            r_count  [TIMER_SLOTS];
    logic [30:0]            r_period [TIMER_SLOTS];
    // Age order: position 0 holds the newest slot
    logic [SLOT_W-1:0]      r_order  [TIMER_SLOTS];
    logic [CNT_W-1:0]       r_cnt;
    logic [31:0]            r_tick_total;

    // Latched request
    logic        r_op_set;
    logic [7:0]  r_key_task;
    logic [7:0]  r_key_sig;
    logic [30:0] r_dur;
    logic        r_per;

    // Walk state
    logic [SLOT_W-1:0] r_idx;
    logic [CNT_W-1:0]  r_wr;
    logic              r_found;
    logic [SLOT_W-1:0] r_found_pos;
    logic [SLOT_W-1:0] r_found_slot;
    logic              r_free_ok;
    logic [SLOT_W-1:0] r_free_slot;
    logic              r_pend_valid;
    logic [7:0]        r_pend_task;
    logic [7:0]        r_pend_sig;
    logic [RES_W-1:0]  r_nres;

    // Result register
    logic    r_out_valid;
    t_kind   r_out_kind;
    t_status r_out_status;
    logic [7:0] r_out_task;
    logic [7:0] r_out_sig;
    logic    r_out_last;

    logic [SLOT_W-1:0] walk_slot;
    logic              pos_live;
    logic              key_hit;
    logic [31:0]       dec_count;
    logic              fire;
    logic              has_period;
    logic              keep;
    logic              capture;
    logic              do_insert;
    logic              do_delete;

    assign walk_slot  = r_order[r_idx];
    assign pos_live   = (CNT_W'(r_idx) < r_cnt);
    assign key_hit    = (r_task[walk_slot] == r_key_task) && (r_sig[walk_slot] == r_key_sig);
    assign dec_count  = r_count[walk_slot] - 32'd1;
    assign fire       = (dec_count == 32'd0) || dec_count[31];
    assign has_period = (r_period[walk_slot] != 31'd0);
    assign keep       = !fire || has_period;
    assign capture    = fire && (r_nres < RES_W'(MAX_RESULTS));
    assign do_insert  = i_cmd.apply && r_op_set && !r_found && r_free_ok;
    assign do_delete  = i_cmd.apply && !r_op_set && r_found;

    assign o_stat.scan_last   = (r_idx == SLOT_W'(TIMER_SLOTS - 1));
    assign o_stat.tick_last   = ((CNT_W'(r_idx) + CNT_W'(1)) == r_cnt);
    assign o_stat.table_empty = (r_cnt == '0);

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_cnt        <= '0;
            r_tick_total <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // strobe on an ack, on the end of a tick, or when a held firing is released
            r_out_valid <= i_cmd.apply || i_cmd.tick_end ||
                           (i_cmd.tick_step && capture && r_pend_valid);
            if (i_cmd.tick_start) begin
                r_tick_total <= r_tick_total + 32'd1;
                r_pend_valid <= 1'b0;
            end
            if (do_insert) begin
                r_valid[r_free_slot] <= 1'b1;
                r_cnt                <= r_cnt + CNT_W'(1);
            end
            if (do_delete) begin
                r_valid[r_found_slot] <= 1'b0;
                r_cnt                 <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.tick_step) begin
                if (!keep) begin
                    r_valid[walk_slot] <= 1'b0;
                end
                if (capture) begin
                    r_pend_valid <= 1'b1;
                end
            end
            if (i_cmd.tick_end) begin
                r_cnt <= r_wr;
            end
        end
    end

    // Payload and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_op_set   <= (t_opcode'(i_opcode) == OP_SET);
            r_key_task <= i_task_id;
            r_key_sig  <= i_signal_id;
            r_dur      <= i_duration;
            r_per      <= i_periodic;
            r_idx      <= '0;
            r_found    <= 1'b0;
            r_free_ok  <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            r_idx <= r_idx + SLOT_W'(1);
            if (pos_live && key_hit && !r_found) begin
                r_found      <= 1'b1;
                r_found_pos  <= r_idx;
                r_found_slot <= walk_slot;
            end
            if (!r_valid[r_idx] && !r_free_ok) begin
                r_free_ok   <= 1'b1;
                r_free_slot <= r_idx;
            end
        end
        if (i_cmd.apply) begin
            r_out_task <= 8'd0;
            r_out_sig  <= 8'd0;
            r_out_last <= 1'b1;
            if (r_op_set) begin
                r_out_kind   <= KIND_SET_ACK;
                r_out_status <= (r_found || r_free_ok) ? STS_OK : STS_FULL;
                if (r_found) begin
                    r_count[r_found_slot] <= {1'b0, r_dur};
                end else if (r_free_ok) begin
                    r_task[r_free_slot]   <= r_key_task;
                    r_sig[r_free_slot]    <= r_key_sig;
                    r_count[r_free_slot]  <= {1'b0, r_dur};
                    r_period[r_free_slot] <= r_per ? r_dur : 31'd0;
                    // push the new slot in front of all others
                    for (int i = TIMER_SLOTS - 1; i > 0; i--) begin
                        r_order[i] <= r_order[i-1];
                    end
                    r_order[0] <= r_free_slot;
                end
            end else begin
                r_out_kind   <= KIND_REMOVE_ACK;
                r_out_status <= r_found ? STS_OK : STS_NOT_FOUND;
                if (r_found) begin
                    // close the gap left by the removed slot
                    for (int i = 0; i < TIMER_SLOTS - 1; i++) begin
                        if (SLOT_W'(i) >= r_found_pos) begin
                            r_order[i] <= r_order[i+1];
                        end
                    end
                end
            end
        end
        if (i_cmd.tick_start) begin
            r_idx  <= '0;
            r_wr   <= '0;
            r_nres <= '0;
        end
        if (i_cmd.tick_step) begin
            r_idx <= r_idx + SLOT_W'(1);
            r_count[walk_slot] <= (fire && has_period) ? {1'b0, r_period[walk_slot]}
                                                       : dec_count;
            if (keep) begin
                r_order[r_wr[SLOT_W-1:0]] <= walk_slot;
                r_wr <= r_wr + CNT_W'(1);
            end
            if (capture) begin
                // release the previous firing, hold this one until the next or the tick end
                r_nres       <= r_nres + RES_W'(1);
                r_pend_task  <= r_task[walk_slot];
                r_pend_sig   <= r_sig[walk_slot];
                r_out_kind   <= KIND_EXPIRED;
                r_out_status <= STS_OK;
                r_out_task   <= r_pend_task;
                r_out_sig    <= r_pend_sig;
                r_out_last   <= 1'b0;
            end
        end
        if (i_cmd.tick_end) begin
            r_out_status <= STS_OK;
            r_out_last   <= 1'b1;
            if (r_pend_valid) begin
                r_out_kind <= KIND_EXPIRED;
                r_out_task <= r_pend_task;
                r_out_sig  <= r_pend_sig;
            end else begin
                r_out_kind <= KIND_TICK_NONE;
                r_out_task <= 8'd0;
                r_out_sig  <= 8'd0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_status       = r_out_status;
    assign o_fired_task   = r_out_task;
    assign o_fired_signal = r_out_sig;
    assign o_last         = r_out_last;
    assign o_tick_count   = r_tick_total;

endmodule

>>> rtl/stt_checker.sv
// Port-level checks for the software timer table, attached by bind.
// Depends on stt_pkg and the software_timer_table port names.
module stt_checker
    import stt_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_opcode,
    input logic       o_valid,
    input logic [1:0] o_kind,
    input logic [1:0] o_status,
    input logic       o_last
);

    // a real command transfer makes the block busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_TICK || i_opcode == OP_SET ||
                            i_opcode == OP_REMOVE)) |=> busy)
        else $error("command transfer did not raise busy");

    // set and remove answer with a single result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_SET_ACK || o_kind == KIND_REMOVE_ACK)) |-> o_last)
        else $error("ack result not marked last");

    // tick-done result is final and ok
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_TICK_NONE) |-> (o_last && o_status == STS_OK))
        else $error("tick-done result malformed");

    // no result directly follows the final result of a command
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result after final result");

    // an intermediate result means the tick walk is still running
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (busy && o_kind == KIND_EXPIRED))
        else $error("intermediate result outside tick walk");

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);

>>> verif/tb_top.sv
// Self-checking testbench for software_timer_table: directed table, then random traffic.
// Predicts results with a shadow timer table; typed directed rows carry their own answer.
// Depends on rtl/stt_pkg.sv and rtl/software_timer_table.sv.
module tb_top;
    import stt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 340;
    localparam int CALM_TAIL    = 60;
    localparam int KEY_POOL     = 20;

    // One expected result as the block reports it.
    typedef struct {
        t_kind       kind;
        t_status     status;
        logic [7:0]  fired_task;
        logic [7:0]  fired_signal;
        logic        last;
        logic [31:0] tick_count;
    } t_timer_result;

    // One row of the directed plan; typed rows carry their single answer.
    typedef struct {
        t_opcode     op;
        logic [7:0]  task_id;
        logic [7:0]  signal_id;
        logic [30:0] duration;
        logic        periodic;
        bit          typed;
        t_kind       kind;
        t_status     status;
        logic [31:0] tick_count;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [7:0]  i_task_id;
    logic [7:0]  i_signal_id;
    logic [30:0] i_duration;
    logic        i_periodic;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [1:0]  o_status;
    logic [7:0]  o_fired_task;
    logic [7:0]  o_fired_signal;
    logic        o_last;
    logic [31:0] o_tick_count;

    software_timer_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_task_id      (i_task_id),
        .i_signal_id    (i_signal_id),
        .i_duration     (i_duration),
        .i_periodic     (i_periodic),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_status       (o_status),
        .o_fired_task   (o_fired_task),
        .o_fired_signal (o_fired_signal),
        .o_last         (o_last),
        .o_tick_count   (o_tick_count)
    );

    // Shadow copy of the timer table, advanced once per accepted transfer.
    bit          slot_live [TIMER_SLOTS];
    logic [7:0]  slot_tid  [TIMER_SLOTS];
    logic [7:0]  slot_sid  [TIMER_SLOTS];
    logic [31:0] slot_cnt  [TIMER_SLOTS];
    logic [30:0] slot_per  [TIMER_SLOTS];
    int          slot_rank [TIMER_SLOTS];
    logic [31:0] ticks_seen;

    t_timer_result due_results [$];
    t_stim_row     directed_plan [$];
    t_timer_result seen_exp;
    int            mismatch_count = 0;
    int            cycle_count = 0;
    logic [7:0]    pool_tid [KEY_POOL];
    logic [7:0]    pool_sid [KEY_POOL];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Abort a hung run; a clean run stays far below this.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("software_timer_table verification failed");
            $finish;
        end
    end

    function automatic t_timer_result make_result(t_kind kind, t_status status,
                                                  logic [7:0] ftask, logic [7:0] fsig);
        t_timer_result res;
        res.kind         = kind;
        res.status       = status;
        res.fired_task   = ftask;
        res.fired_signal = fsig;
        res.last         = 1'b0;
        res.tick_count   = ticks_seen;
        return res;
    endfunction

    function automatic int find_timer(logic [7:0] tid, logic [7:0] sid);
        int hit;
        hit = -1;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (slot_live[i] && slot_tid[i] == tid && slot_sid[i] == sid) hit = i;
        end
        return hit;
    endfunction

    // Apply one transfer to the shadow table and queue the results it causes.
    task automatic timer_table_step(input t_opcode op, input logic [7:0] tid,
                                    input logic [7:0] sid, input logic [30:0] dur,
                                    input logic per);
        t_timer_result batch [$];
        int            hit;
        int            free_slot;
        int            cnt;
        int            next_rank;
        int            s;
        int            order [TIMER_SLOTS];
        bit            found;
        logic [31:0]   c;
        t_status       st;
        case (op)
            OP_SET: begin
                st  = STS_OK;
                hit = find_timer(tid, sid);
                if (hit >= 0) begin
                    // Existing key: reload the counter only, keep the period.
                    slot_cnt[hit] = {1'b0, dur};
                end else begin
                    free_slot = -1;
                    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
                        if (!slot_live[i]) free_slot = i;
                    end
                    if (free_slot < 0) begin
                        st = STS_FULL;
                    end else begin
                        // Age every live entry, then insert as the newest.
                        for (int i = 0; i < TIMER_SLOTS; i++) begin
                            if (slot_live[i]) slot_rank[i]++;
                        end
                        slot_live[free_slot] = 1'b1;
                        slot_tid[free_slot]  = tid;
                        slot_sid[free_slot]  = sid;
                        slot_cnt[free_slot]  = {1'b0, dur};
                        slot_per[free_slot]  = per ? dur : 31'd0;
                        slot_rank[free_slot] = 0;
                    end
                end
                batch.push_back(make_result(KIND_SET_ACK, st, 8'd0, 8'd0));
            end
            OP_REMOVE: begin
                st  = STS_NOT_FOUND;
                hit = find_timer(tid, sid);
                if (hit >= 0) begin
                    slot_live[hit] = 1'b0;
                    for (int i = 0; i < TIMER_SLOTS; i++) begin
                        if (slot_live[i] && slot_rank[i] > slot_rank[hit]) slot_rank[i]--;
                    end
                    st = STS_OK;
                end
                batch.push_back(make_result(KIND_REMOVE_ACK, st, 8'd0, 8'd0));
            end
            OP_TICK: begin
                ticks_seen = ticks_seen + 32'd1;
                cnt = 0;
                // Walk from the newest entry to the oldest.
                for (int r = 0; r < TIMER_SLOTS; r++) begin
                    found = 1'b0;
                    for (int i = 0; i < TIMER_SLOTS; i++) begin
                        if (!found && slot_live[i] && slot_rank[i] == r) begin
                            order[cnt] = i;
                            cnt++;
                            found = 1'b1;
                        end
                    end
                end
                for (int r = 0; r < cnt; r++) begin
                    s = order[r];
                    c = slot_cnt[s] - 32'd1;
                    slot_cnt[s] = c;
                    // Fire at zero or below, as a signed counter.
                    if (c == 32'd0 || c[31]) begin
                        if (batch.size() < MAX_RESULTS) begin
                            batch.push_back(make_result(KIND_EXPIRED, STS_OK,
                                                        slot_tid[s], slot_sid[s]));
                        end
                        if (slot_per[s] != 31'd0) slot_cnt[s] = {1'b0, slot_per[s]};
                        else slot_live[s] = 1'b0;
                    end
                end
                // Close up the age ranks of the survivors.
                next_rank = 0;
                for (int r = 0; r < cnt; r++) begin
                    if (slot_live[order[r]]) begin
                        slot_rank[order[r]] = next_rank;
                        next_rank++;
                    end
                end
                if (batch.size() == 0) begin
                    batch.push_back(make_result(KIND_TICK_NONE, STS_OK, 8'd0, 8'd0));
                end
            end
            default: ;
        endcase
        if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k]) due_results.push_back(batch[k]);
    endtask

    function automatic void add_row(t_opcode op, logic [7:0] tid, logic [7:0] sid,
                                    logic [30:0] dur, logic per, bit typed,
                                    t_kind kind, t_status st, logic [31:0] tc);
        t_stim_row row;
        row.op         = op;
        row.task_id    = tid;
        row.signal_id  = sid;
        row.duration   = dur;
        row.periodic   = per;
        row.typed      = typed;
        row.kind       = kind;
        row.status     = st;
        row.tick_count = tc;
        directed_plan.push_back(row);
    endfunction

    // Put junk on the fields while start is low.
    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start       = 1'b0;
            i_opcode    = 2'($urandom_range(0, 3));
            i_task_id   = 8'($urandom);
            i_signal_id = 8'($urandom);
            i_duration  = 31'($urandom);
            i_periodic  = 1'($urandom);
        end
    endtask

    // Present one command and hold it until the block takes it, then predict.
    task automatic send_item(input t_opcode op, input logic [7:0] tid,
                             input logic [7:0] sid, input logic [30:0] dur,
                             input logic per);
        bit taken;
        @(negedge i_clk);
        start       = 1'b1;
        i_opcode    = op;
        i_task_id   = tid;
        i_signal_id = sid;
        i_duration  = dur;
        i_periodic  = per;
        taken       = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!busy) taken = 1'b1;
            else @(negedge i_clk);
        end
        timer_table_step(op, tid, sid, dur, per);
    endtask

    task automatic wait_drained;
        @(negedge i_clk);
        start = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    // Compare every strobed result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (due_results.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("%0t unexpected result kind=%0d status=%0d task=%02h signal=%02h",
                             $time, o_kind, o_status, o_fired_task, o_fired_signal);
                end
                mismatch_count++;
            end else begin
                seen_exp = due_results.pop_front();
                if (o_kind !== seen_exp.kind || o_status !== seen_exp.status ||
                    o_fired_task !== seen_exp.fired_task ||
                    o_fired_signal !== seen_exp.fired_signal ||
                    o_last !== seen_exp.last || o_tick_count !== seen_exp.tick_count) begin
                    if (mismatch_count < 10) begin
                        $display("%0t mismatch: expected kind=%0d status=%0d task=%02h %s",
                                 $time, seen_exp.kind, seen_exp.status,
                                 seen_exp.fired_task, "");
                        $display("    expected signal=%02h last=%0b ticks=%0d",
                                 seen_exp.fired_signal, seen_exp.last,
                                 seen_exp.tick_count);
                        $display("    got kind=%0d status=%0d task=%02h signal=%02h last=%0b ticks=%0d",
                                 o_kind, o_status, o_fired_task, o_fired_signal,
                                 o_last, o_tick_count);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        t_opcode     op;
        logic [7:0]  tid;
        logic [7:0]  sid;
        logic [30:0] dur;
        logic        per;
        int          pick;
        int          done_items;
        bit          idle_on;
        t_timer_result typed_res;

        ticks_seen     = 32'd0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_rank[i] = 0;
        end

        // Hold every input known while reset is applied.
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_opcode    = OP_TICK;
        i_task_id   = 8'd0;
        i_signal_id = 8'd0;
        i_duration  = 31'd0;
        i_periodic  = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed plan: empty table, extremes, zero durations, reload of a
        // live key, a full table and a tick that fires every slot at once.
        add_row(OP_TICK,   8'h00, 8'h00, 31'd0, 1'b0, 1, KIND_TICK_NONE, STS_OK, 32'd1);
        add_row(OP_REMOVE, 8'h00, 8'h00, 31'd0, 1'b0, 1, KIND_REMOVE_ACK, STS_NOT_FOUND,
                32'd1);
        add_row(OP_SET,    8'hFF, 8'hFF, 31'h7FFF_FFFF, 1'b1, 1, KIND_SET_ACK, STS_OK,
                32'd1);
        add_row(OP_SET,    8'h00, 8'h00, 31'd0, 1'b0, 1, KIND_SET_ACK, STS_OK, 32'd1);
        // Periodic with zero duration acts as one-shot.
        add_row(OP_SET,    8'hAA, 8'h55, 31'd0, 1'b1, 1, KIND_SET_ACK, STS_OK, 32'd1);
        add_row(OP_TICK,   8'h00, 8'h00, 31'd0, 1'b0, 0, KIND_TICK_NONE, STS_OK, 32'd0);
        add_row(OP_NONE,   8'hFF, 8'hFF, 31'h7FFF_FFFF, 1'b1, 0, KIND_TICK_NONE, STS_OK,
                32'd0);
        // Fill the table; the last key already lives, so only its counter reloads.
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            add_row(OP_SET, 8'(i * 17), 8'(i * 17), 31'd1, 1'(i), 1, KIND_SET_ACK,
                    STS_OK, 32'd2);
        end
        add_row(OP_SET,    8'h12, 8'h34, 31'd5, 1'b0, 1, KIND_SET_ACK, STS_FULL, 32'd2);
        add_row(OP_TICK,   8'h00, 8'h00, 31'd0, 1'b0, 0, KIND_TICK_NONE, STS_OK, 32'd0);
        add_row(OP_REMOVE, 8'hFF, 8'hFF, 31'd0, 1'b0, 1, KIND_REMOVE_ACK, STS_OK, 32'd3);

        foreach (directed_plan[k]) begin
            send_item(directed_plan[k].op, directed_plan[k].task_id,
                      directed_plan[k].signal_id, directed_plan[k].duration,
                      directed_plan[k].periodic);
            if (directed_plan[k].typed) begin
                // Swap the predicted answer for the one typed into the plan.
                void'(due_results.pop_back());
                typed_res.kind         = directed_plan[k].kind;
                typed_res.status       = directed_plan[k].status;
                typed_res.fired_task   = 8'd0;
                typed_res.fired_signal = 8'd0;
                typed_res.last         = 1'b1;
                typed_res.tick_count   = directed_plan[k].tick_count;
                due_results.push_back(typed_res);
            end
            if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 16));
        end

        // A small key pool makes reloads, removes that hit and a full table common.
        for (int k = 0; k < KEY_POOL; k++) begin
            pool_tid[k] = 8'($urandom);
            pool_sid[k] = 8'($urandom);
        end

        done_items = 0;
        idle_on    = 1'b1;
        while (done_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 38)      op = OP_TICK;
            else if (pick < 78) op = OP_SET;
            else if (pick < 95) op = OP_REMOVE;
            else                op = OP_NONE;

            pick = $urandom_range(0, KEY_POOL - 1);
            if ($urandom_range(0, 9) == 0) begin
                tid = 8'($urandom);
                sid = 8'($urandom);
            end else begin
                tid = pool_tid[pick];
                sid = pool_sid[pick];
            end

            // Mostly short timers so firings are frequent; some never expire.
            pick = $urandom_range(0, 9);
            if (pick < 7)       dur = 31'($urandom_range(0, 6));
            else if (pick < 9)  dur = 31'($urandom_range(0, 40));
            else                dur = 31'($urandom);
            per = 1'($urandom);

            send_item(op, tid, sid, dur, per);
            if (op != OP_NONE) done_items++;

            // Toggle idling on and off in stretches; keep the tail back-to-back.
            if (done_items % 25 == 0) idle_on = ($urandom_range(0, 2) != 0);
            if (done_items == RANDOM_ITEMS / 2) wait_drained;
            if (idle_on && done_items < RANDOM_ITEMS - CALM_TAIL &&
                $urandom_range(0, 99) < 35) begin
                idle_cycles($urandom_range(1, 16));
            end
        end

        wait_drained;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("software_timer_table verification clean");
        end else begin
            $display("software_timer_table verification failed");
        end
        $finish;
    end

endmodule
